@@ src/lldq_pkg.sv @@
// shared types, op and status codes for the linked list deque engine
`default_nettype none
package lldq_pkg;
	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_AFTER = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;
	localparam logic [2:0] OP_DEL_KEY   = 3'd5;
	localparam logic [2:0] OP_SEARCH    = 3'd6;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] key;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] position;
		logic [6:0] length;
	} rsp_t;
endpackage
`default_nettype wire

@@ src/lldq_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module lldq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ src/linked_list_deque_engine.sv @@
// top level: sequencer, node pool rams and result register of the deque engine
// insert front/back: free slot scan, one slot a cycle, then the link writes
// delete front/back: read then unlink; search and delete key walk one node a cycle
// insert after: walks, then scans for a free slot; the finish state waits while the output stalls
// throughput: one request at a time, a finished result waits while the next request is taken
// reset: arst_n clears the list to empty, all pool slots free, no result pending
`default_nettype none
module linked_list_deque_engine #(
	parameter int CAPACITY   = lldq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = lldq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lldq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lldq_pkg::rsp_t      rsp
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_LRD    = 4'd3;
	localparam logic [3:0] S_LW1    = 4'd4;
	localparam logic [3:0] S_LW2    = 4'd5;
	localparam logic [3:0] S_WSTART = 4'd6;
	localparam logic [3:0] S_WALK   = 4'd7;
	localparam logic [3:0] S_URD    = 4'd8;
	localparam logic [3:0] S_UWR    = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0]            state_q;
	logic [2:0]            op_q;
	logic [DATA_WIDTH-1:0] key_q, val_q;
	logic [AW-1:0]         head_q, tail_q, t_q, n_q, s_q, cur_q, fs_q, idx_q;
	logic [CW-1:0]         count_q;
	logic [CAPACITY-1:0]   in_use_q;
	logic [1:0]            st_q;
	logic [CW-1:0]         pos_q;
	logic                  out_vld_q;
	lldq_pkg::rsp_t        out_q;

	// input words as stored data: sign extend, then keep the low data bits
	logic signed [63:0] key_ext, val_ext;
	assign key_ext = 64'(req.key);
	assign val_ext = 64'(req.new_value);

	// pool ram ports, all three rams share one read address
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] val_rdata;
	logic [AW-1:0]         next_rdata, prev_rdata;
	logic                  val_we, next_we, prev_we;
	logic [AW-1:0]         next_waddr, next_wdata, prev_waddr, prev_wdata;
	logic                  key_hit;
	logic                  last_node;

	lldq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(val_we), .waddr(fs_q), .wdata(val_q),
		.raddr(raddr), .rdata(val_rdata)
	);
	lldq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(raddr), .rdata(next_rdata)
	);
	lldq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(raddr), .rdata(prev_rdata)
	);

	// shared key compare used on every step of the walk
	assign key_hit   = (val_rdata == key_q);
	assign last_node = ((CW'(idx_q) + CW'(1)) == count_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	// read address: the walk follows the link straight out of the ram
	always_comb begin
		unique case (state_q)
			S_WSTART: raddr = head_q;
			S_WALK:   raddr = next_rdata;
			default:  raddr = t_q;
		endcase
	end

	// link writes
	always_comb begin
		val_we     = 1'b0;
		next_we    = 1'b0;
		prev_we    = 1'b0;
		next_waddr = n_q;
		next_wdata = n_q;
		prev_waddr = n_q;
		prev_wdata = n_q;
		unique case (state_q)
			S_SCAN: begin
				// a free slot found: store the word, self links for a lone node
				if (!in_use_q[fs_q]) begin
					val_we     = 1'b1;
					next_we    = (count_q == '0);
					prev_we    = (count_q == '0);
					next_waddr = fs_q;
					next_wdata = fs_q;
					prev_waddr = fs_q;
					prev_wdata = fs_q;
				end
			end
			S_LW1: begin
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_wdata = next_rdata;
				prev_wdata = t_q;
			end
			S_LW2: begin
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_waddr = t_q;
				prev_waddr = s_q;
			end
			S_UWR: begin
				// bypass the node being removed
				next_we    = (count_q > CW'(1));
				prev_we    = (count_q > CW'(1));
				next_waddr = prev_rdata;
				next_wdata = next_rdata;
				prev_waddr = next_rdata;
				prev_wdata = prev_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			in_use_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// result register frees on a transfer unless a new result loads now
			if (out_vld_q && !rsp_stall && state_q != S_FIN) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.op;
						key_q   <= key_ext[DATA_WIDTH-1:0];
						val_q   <= val_ext[DATA_WIDTH-1:0];
						st_q    <= lldq_pkg::ST_DONE;
						pos_q   <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					fs_q <= '0;
					case (op_q) inside
						lldq_pkg::OP_INS_FRONT, lldq_pkg::OP_INS_BACK: begin
							t_q     <= tail_q;
							state_q <= S_SCAN;
						end
						lldq_pkg::OP_INS_AFTER, lldq_pkg::OP_DEL_FRONT,
						lldq_pkg::OP_DEL_BACK, lldq_pkg::OP_DEL_KEY,
						lldq_pkg::OP_SEARCH: begin
							if (count_q == '0) begin
								st_q    <= lldq_pkg::ST_EMPTY;
								state_q <= S_FIN;
							end else if (op_q == lldq_pkg::OP_DEL_FRONT) begin
								t_q     <= head_q;
								state_q <= S_URD;
							end else if (op_q == lldq_pkg::OP_DEL_BACK) begin
								t_q     <= tail_q;
								state_q <= S_URD;
							end else begin
								state_q <= S_WSTART;
							end
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_SCAN: begin
					if (!in_use_q[fs_q]) begin
						n_q            <= fs_q;
						in_use_q[fs_q] <= 1'b1;
						if (count_q == '0) begin
							head_q  <= fs_q;
							tail_q  <= fs_q;
							count_q <= count_q + CW'(1);
							state_q <= S_FIN;
						end else begin
							state_q <= S_LRD;
						end
					end else if (fs_q == LAST) begin
						st_q    <= lldq_pkg::ST_FULL;
						state_q <= S_FIN;
					end else begin
						fs_q <= fs_q + AW'(1);
					end
				end
				S_LRD: begin
					state_q <= S_LW1;
				end
				S_LW1: begin
					s_q     <= next_rdata;
					state_q <= S_LW2;
				end
				S_LW2: begin
					count_q <= count_q + CW'(1);
					if (op_q == lldq_pkg::OP_INS_FRONT) begin
						head_q <= n_q;
					end else if (t_q == tail_q) begin
						tail_q <= n_q;
					end
					state_q <= S_FIN;
				end
				S_WSTART: begin
					cur_q   <= head_q;
					idx_q   <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (key_hit) begin
						t_q <= cur_q;
						if (op_q == lldq_pkg::OP_SEARCH) begin
							pos_q   <= CW'(idx_q) + CW'(1);
							state_q <= S_FIN;
						end else if (op_q == lldq_pkg::OP_DEL_KEY) begin
							state_q <= S_URD;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (last_node) begin
						st_q    <= lldq_pkg::ST_NOTFOUND;
						state_q <= S_FIN;
					end else begin
						cur_q <= next_rdata;
						idx_q <= idx_q + AW'(1);
					end
				end
				S_URD: begin
					state_q <= S_UWR;
				end
				S_UWR: begin
					if (count_q <= CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						if (t_q == head_q) begin
							head_q <= next_rdata;
						end
						if (t_q == tail_q) begin
							tail_q <= prev_rdata;
						end
					end
					in_use_q[t_q] <= 1'b0;
					count_q       <= count_q - CW'(1);
					state_q       <= S_FIN;
				end
				S_FIN: begin
					// wait for the result register to be free
					if (!out_vld_q || !rsp_stall) begin
						out_q.status   <= st_q;
						out_q.position <= 7'(pos_q);
						out_q.length   <= 7'(count_q);
						out_vld_q      <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/lldq_chk.sv @@
// port level checks for the deque engine, bound to the top level
`default_nettype none
module lldq_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire lldq_pkg::rsp_t rsp
);
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result dropped or changed while stalled");

	a_pos_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.position == 7'd0 || rsp.status == lldq_pkg::ST_DONE))
		else $error("position reported on a failed request");

	a_pos_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.position != 7'd0 |-> rsp.position <= rsp.length)
		else $error("position beyond list length");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == lldq_pkg::ST_EMPTY |-> rsp.length == 7'd0)
		else $error("empty status with nonzero length");
endmodule

bind linked_list_deque_engine lldq_chk u_lldq_chk (.*);
`default_nettype wire

@@ tb/tb_linked_list_deque_engine.sv @@
// self-checking testbench for the linked list deque engine
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: holds a copy of the list and the queue of expected responses
class deque_scoreboard;
	int                    list_q[$];
	int                    slot_q[$];
	bit                    slot_used[64];
	lldq_pkg::rsp_t        pending_q[$];
	int                    mismatches;

	function int lowest_free();
		for (int i = 0; i < 64; i++)
			if (!slot_used[i]) return i;
		return 64;
	endfunction

	function int find_pos(int k);
		foreach (list_q[i])
			if (list_q[i] == k) return i + 1;
		return 0;
	endfunction

	// note an accepted request and work out its response
	function void note_request(lldq_pkg::req_t r);
		lldq_pkg::rsp_t e;
		int n;
		int p;
		e.status   = lldq_pkg::ST_DONE;
		e.position = '0;
		case (r.op) inside
			lldq_pkg::OP_INS_FRONT, lldq_pkg::OP_INS_BACK: begin
				n = lowest_free();
				if (n == 64) e.status = lldq_pkg::ST_FULL;
				else begin
					slot_used[n] = 1'b1;
					if (r.op == lldq_pkg::OP_INS_FRONT) begin
						list_q.push_front(r.new_value);
						slot_q.push_front(n);
					end else begin
						list_q.push_back(r.new_value);
						slot_q.push_back(n);
					end
				end
			end
			lldq_pkg::OP_INS_AFTER, lldq_pkg::OP_DEL_FRONT, lldq_pkg::OP_DEL_BACK,
			lldq_pkg::OP_DEL_KEY, lldq_pkg::OP_SEARCH: begin
				if (list_q.size() == 0) e.status = lldq_pkg::ST_EMPTY;
				else if (r.op == lldq_pkg::OP_DEL_FRONT) begin
					slot_used[slot_q[0]] = 1'b0;
					void'(list_q.pop_front());
					void'(slot_q.pop_front());
				end else if (r.op == lldq_pkg::OP_DEL_BACK) begin
					slot_used[slot_q[$]] = 1'b0;
					void'(list_q.pop_back());
					void'(slot_q.pop_back());
				end else begin
					p = find_pos(r.key);
					if (p == 0) e.status = lldq_pkg::ST_NOTFOUND;
					else if (r.op == lldq_pkg::OP_SEARCH) e.position = p[6:0];
					else if (r.op == lldq_pkg::OP_DEL_KEY) begin
						slot_used[slot_q[p-1]] = 1'b0;
						list_q.delete(p - 1);
						slot_q.delete(p - 1);
					end else begin
						n = lowest_free();
						if (n == 64) e.status = lldq_pkg::ST_FULL;
						else begin
							slot_used[n] = 1'b1;
							list_q.insert(p, r.new_value);
							slot_q.insert(p, n);
						end
					end
				end
			end
			default: ;
		endcase
		e.length = 7'(list_q.size());
		pending_q.push_back(e);
	endfunction

	function void check_response(lldq_pkg::rsp_t got);
		lldq_pkg::rsp_t e;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected response %p", got);
			return;
		end
		e = pending_q.pop_front();
		if (got.status !== e.status || got.position !== e.position
				|| got.length !== e.length) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %p actual %p", e, got);
		end
	endfunction
endclass

module tb_linked_list_deque_engine;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lldq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lldq_pkg::rsp_t rsp;

	deque_scoreboard sb = new();
	int idle_cycles = 0;
	bit stall_enable = 1'b1;
	// small pool of key values so matches happen often
	int key_pool[8];

	always #4 clk = ~clk;

	linked_list_deque_engine dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// transfer bookkeeping on the edge itself, sampled values only
	always @(posedge clk) begin
		if (req_valid && !req_stall) sb.note_request(req);
		if (rsp_valid && !rsp_stall) sb.check_response(rsp);
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	// receiver stall pattern: long free stretches mixed with random stalls
	always @(posedge clk) begin
		if (!stall_enable) rsp_stall <= 1'b0;
		else if (($urandom % 64) < 16) rsp_stall <= 1'b0;
		else rsp_stall <= (($urandom % 4) == 0);
	end

	always @(posedge clk)
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end

	// one transfer; valid stays high into the next call when back to back
	task automatic send_request(input logic [2:0] op, input int k, input int v);
		req_valid <= 1'b1;
		req <= '{op: op, key: k, new_value: v};
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic pause(input int n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic int pick_value();
		if ($urandom_range(0, 3) == 0) return int'($urandom);
		return key_pool[$urandom_range(0, 7)];
	endfunction

	task automatic send_random();
		int r;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		// insert-heavy mix with occasional unused op code
		if (r < 20) op = lldq_pkg::OP_INS_FRONT;
		else if (r < 42) op = lldq_pkg::OP_INS_BACK;
		else if (r < 55) op = lldq_pkg::OP_INS_AFTER;
		else if (r < 63) op = lldq_pkg::OP_DEL_FRONT;
		else if (r < 71) op = lldq_pkg::OP_DEL_BACK;
		else if (r < 82) op = lldq_pkg::OP_DEL_KEY;
		else if (r < 98) op = lldq_pkg::OP_SEARCH;
		else op = 3'd7;
		send_request(op, pick_value(), pick_value());
	endtask

	initial begin
		int burst;
		key_pool = '{0, -1, 32'h7fffffff, 32'h80000000, 5, 77, -300, 1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list cases, field extremes, every op, unused code
		stall_enable = 1'b0;
		send_request(lldq_pkg::OP_DEL_FRONT, 0, 0);
		send_request(lldq_pkg::OP_DEL_BACK, 0, 0);
		send_request(lldq_pkg::OP_SEARCH, 5, 0);
		send_request(lldq_pkg::OP_DEL_KEY, 5, 0);
		send_request(lldq_pkg::OP_INS_AFTER, 5, 1);
		send_request(lldq_pkg::OP_INS_FRONT, 0, 32'h7fffffff);
		send_request(lldq_pkg::OP_INS_BACK, 0, 32'h80000000);
		send_request(lldq_pkg::OP_INS_AFTER, 32'h80000000, -1);
		send_request(lldq_pkg::OP_INS_AFTER, 32'h7fffffff, 0);
		send_request(lldq_pkg::OP_SEARCH, -1, 0);
		send_request(lldq_pkg::OP_SEARCH, 12345, 0);
		send_request(3'd7, -1, -1);
		send_request(lldq_pkg::OP_DEL_KEY, 0, 0);
		send_request(lldq_pkg::OP_DEL_KEY, 999, 0);
		send_request(lldq_pkg::OP_DEL_FRONT, 0, 0);
		send_request(lldq_pkg::OP_DEL_BACK, 0, 0);
		send_request(lldq_pkg::OP_DEL_BACK, 0, 0);
		send_request(lldq_pkg::OP_DEL_BACK, 0, 0);
		stall_enable = 1'b1;

		// fill the pool to hit the full cases, then drain part of it
		for (int i = 0; i < 64; i++) send_request(lldq_pkg::OP_INS_BACK, 0, i);
		send_request(lldq_pkg::OP_INS_FRONT, 0, 1);
		send_request(lldq_pkg::OP_INS_BACK, 0, 1);
		send_request(lldq_pkg::OP_INS_AFTER, 63, 1);
		send_request(lldq_pkg::OP_INS_AFTER, 1000, 1);
		send_request(lldq_pkg::OP_SEARCH, 63, 0);
		for (int i = 0; i < 40; i++)
			send_request(lldq_pkg::OP_DEL_KEY, $urandom_range(0, 63), 0);

		// random part in bursts with random gaps
		for (int sent = 0; sent < 280; ) begin
			burst = $urandom_range(1, 20);
			for (int j = 0; j < burst; j++) send_random();
			sent += burst;
			if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
		end
		req_valid <= 1'b0;

		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

`default_nettype wire
